### hw/rtl/resp_reply_parser_assert.svh
// Assertion macros used by the checker file of the reply parser.
`ifndef RESP_REPLY_PARSER_ASSERT_SVH
`define RESP_REPLY_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define RESP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define RESP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/resp_pkg.sv
package resp_pkg;

	localparam int CNT_W = 31;

	typedef enum logic [2:0] {
		PH_TYPE,
		PH_LINE,
		PH_NUM,
		PH_BULK,
		PH_TAIL,
		PH_SKIP
	} ph_t;

	typedef enum logic [2:0] {
		K_SIMPLE = 3'd0,
		K_ERROR  = 3'd1,
		K_BULK   = 3'd2,
		K_INT    = 3'd3,
		K_NULL   = 3'd4,
		K_ARRAY  = 3'd5,
		K_BAD    = 3'd6
	} kind_t;

	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef struct packed {
		logic             push;
		logic             pop;
		logic             clear;
		logic [CNT_W-1:0] count;
	} stk_cmd_t;

	typedef struct packed {
		logic full;
		logic last;
	} stk_stat_t;

endpackage

### hw/rtl/resp_num.sv
module resp_num (
	input  logic [31:0] accum,
	input  logic        neg,
	input  logic [3:0]  digit,
	output logic [31:0] accum_next,
	output logic        sat
);
	logic [35:0] prod;
	logic [35:0] limit;

	// The magnitude may reach one more when the value is negative.
	always_comb begin
		prod  = {1'b0, accum, 3'b000} + {3'b000, accum, 1'b0} + {32'd0, digit};
		limit = neg ? 36'h0_8000_0000 : 36'h0_7FFF_FFFF;
		sat   = prod > limit;
		accum_next = sat ? limit[31:0] : prod[31:0];
	end

endmodule

### hw/rtl/resp_stack.sv
module resp_stack #(
	parameter int MAX_DEPTH = 4,
	parameter int DW = $clog2(MAX_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  resp_pkg::stk_cmd_t  cmd,
	output resp_pkg::stk_stat_t stat,
	output logic [DW-1:0]       depth
);
	import resp_pkg::*;

	localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	logic [CNT_W-1:0]     counts_q [MAX_DEPTH];
	logic [DW-1:0]        depth_q;
	logic [DW-1:0]        new_depth;
	logic                 found;
	logic [MAX_DEPTH-1:0] dec_en;

	// Closing an element pops every level whose count runs out and
	// decrements the innermost level that still has elements to come.
	always_comb begin
		found     = 1'b0;
		new_depth = '0;
		dec_en    = '0;
		for (int i = 0; i < MAX_DEPTH; i++) begin
			if (DW'(i) < depth_q && counts_q[i] != CNT_W'(1)) begin
				found     = 1'b1;
				new_depth = DW'(i + 1);
			end
		end
		for (int i = 0; i < MAX_DEPTH; i++) begin
			dec_en[i] = found && (new_depth == DW'(i + 1));
		end
	end

	assign stat.full = (depth_q == DW'(MAX_DEPTH));
	assign stat.last = !found;
	assign depth     = depth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (cmd.clear) begin
			depth_q <= '0;
		end else if (cmd.push) begin
			depth_q <= depth_q + DW'(1);
		end else if (cmd.pop) begin
			depth_q <= new_depth;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_DEPTH; i++) begin
			if (cmd.push && depth_q[IW-1:0] == IW'(i)) begin
				counts_q[i] <= cmd.count;
			end else if (cmd.pop && dec_en[i]) begin
				counts_q[i] <= counts_q[i] - CNT_W'(1);
			end
		end
	end

endmodule

### hw/rtl/resp_reply_parser.sv
// Path: a byte is registered in the input register, and any result it yields in the result register.
// Throughput: one byte per cycle; the input register and the result register sit
// back to back, and in_ready falls only while a held result is not taken.
// Reset: arst_n clears the valid flags of both registers, sets the parser to await a
// type byte and empties the array stack at once; there is no clearing pass.
module resp_reply_parser #(
	parameter int MAX_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         kind,
	output logic               has_byte,
	output logic [7:0]         payload_byte,
	output logic signed [31:0] number,
	output logic               number_overflow,
	output logic               element_end,
	output logic [2:0]         nest_level,
	output logic               reply_end
);
	import resp_pkg::*;

	localparam int DW = $clog2(MAX_DEPTH + 1);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             step;

	ph_t              phase_q;
	ph_t              phase_d;
	kind_t            etype_q;
	kind_t            etype_d;
	logic [31:0]      accum_q;
	logic [31:0]      accum_d;
	logic             neg_q;
	logic             neg_d;
	logic             ovf_q;
	logic             ovf_d;
	logic [CNT_W-1:0] left_q;
	logic [CNT_W-1:0] left_d;

	logic [31:0]      acc_next;
	logic             acc_sat;
	logic [31:0]      value;
	logic             is_lf;
	logic             is_digit;

	stk_cmd_t         cmd_c;
	stk_cmd_t         stk_cmd;
	stk_stat_t        stk_stat;
	logic [DW-1:0]    depth;

	logic             r_valid;
	kind_t            r_kind;
	logic             r_has;
	logic [7:0]       r_byte;
	logic [31:0]      r_number;
	logic             r_ovf;
	logic             r_end;
	logic             r_rend;

	logic             out_valid_q;
	logic [2:0]       kind_q;
	logic             has_q;
	logic [7:0]       byte_q;
	logic [31:0]      number_q;
	logic             ovf_out_q;
	logic             end_q;
	logic [2:0]       nest_q;
	logic             rend_q;

	assign step     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	resp_num u_num (
		.accum      (accum_q),
		.neg        (neg_q),
		.digit      (byte_s1[3:0]),
		.accum_next (acc_next),
		.sat        (acc_sat)
	);

	assign is_lf    = (byte_s1 == CH_LF);
	assign is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign value    = neg_q ? 32'd0 - accum_q : accum_q;

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_TYPE: begin
				if (byte_s1 == CH_PLUS || byte_s1 == CH_MINUS) begin
					phase_d = PH_LINE;
				end else if (byte_s1 == CH_COLON || byte_s1 == CH_DOLLAR ||
						byte_s1 == CH_STAR) begin
					phase_d = PH_NUM;
				end else if (!is_lf) begin
					phase_d = PH_SKIP;
				end
			end
			PH_LINE: begin
				if (is_lf) begin
					phase_d = PH_TYPE;
				end
			end
			PH_NUM: begin
				if (is_lf) begin
					if (etype_q == K_BULK && !(neg_q && accum_q != 32'd0)) begin
						phase_d = (accum_q == 32'd0) ? PH_TAIL : PH_BULK;
					end else begin
						phase_d = PH_TYPE;
					end
				end
			end
			PH_BULK: begin
				if (left_q == CNT_W'(1)) begin
					phase_d = PH_TAIL;
				end
			end
			PH_TAIL: begin
				if (is_lf) begin
					phase_d = PH_TYPE;
				end
			end
			PH_SKIP: begin
				if (is_lf) begin
					phase_d = PH_TYPE;
				end
			end
			default: begin
				phase_d = PH_TYPE;
			end
		endcase
	end

	always_comb begin
		etype_d  = etype_q;
		accum_d  = accum_q;
		neg_d    = neg_q;
		ovf_d    = ovf_q;
		left_d   = left_q;
		cmd_c    = '0;
		r_valid  = 1'b0;
		r_kind   = K_SIMPLE;
		r_has    = 1'b0;
		r_byte   = 8'd0;
		r_number = 32'd0;
		r_ovf    = 1'b0;
		r_end    = 1'b0;
		r_rend   = 1'b0;
		unique case (phase_q)
			PH_TYPE: begin
				accum_d = 32'd0;
				neg_d   = 1'b0;
				ovf_d   = 1'b0;
				left_d  = '0;
				if (byte_s1 == CH_PLUS) begin
					etype_d = K_SIMPLE;
				end else if (byte_s1 == CH_MINUS) begin
					etype_d = K_ERROR;
				end else if (byte_s1 == CH_COLON) begin
					etype_d = K_INT;
				end else if (byte_s1 == CH_DOLLAR) begin
					etype_d = K_BULK;
				end else if (byte_s1 == CH_STAR) begin
					etype_d = K_ARRAY;
				end else begin
					r_valid     = 1'b1;
					r_kind      = K_BAD;
					r_has       = 1'b1;
					r_byte      = byte_s1;
					r_end       = 1'b1;
					r_rend      = 1'b1;
					cmd_c.clear = 1'b1;
				end
			end
			PH_LINE: begin
				if (is_lf) begin
					r_valid   = 1'b1;
					r_kind    = etype_q;
					r_end     = 1'b1;
					r_rend    = stk_stat.last;
					cmd_c.pop = 1'b1;
				end else if (byte_s1 != CH_CR) begin
					r_valid = 1'b1;
					r_kind  = etype_q;
					r_has   = 1'b1;
					r_byte  = byte_s1;
				end
			end
			PH_NUM: begin
				if (is_digit) begin
					accum_d = acc_next;
					if (acc_sat) begin
						ovf_d = 1'b1;
					end
				end else if (byte_s1 == CH_MINUS && accum_q == 32'd0) begin
					neg_d = 1'b1;
				end else if (is_lf) begin
					if (etype_q == K_INT || (neg_q && accum_q != 32'd0)) begin
						r_valid   = 1'b1;
						r_kind    = (etype_q == K_INT) ? K_INT : K_NULL;
						r_number  = value;
						r_ovf     = ovf_q;
						r_end     = 1'b1;
						r_rend    = stk_stat.last;
						cmd_c.pop = 1'b1;
					end else if (etype_q == K_BULK) begin
						left_d = accum_q[CNT_W-1:0];
					end else if (accum_q == 32'd0) begin
						r_valid   = 1'b1;
						r_kind    = K_ARRAY;
						r_ovf     = ovf_q;
						r_end     = 1'b1;
						r_rend    = stk_stat.last;
						cmd_c.pop = 1'b1;
					end else if (stk_stat.full) begin
						r_valid     = 1'b1;
						r_kind      = K_BAD;
						r_number    = value;
						r_ovf       = ovf_q;
						r_end       = 1'b1;
						r_rend      = 1'b1;
						cmd_c.clear = 1'b1;
					end else begin
						r_valid     = 1'b1;
						r_kind      = K_ARRAY;
						r_number    = value;
						r_ovf       = ovf_q;
						r_end       = 1'b1;
						cmd_c.push  = 1'b1;
						cmd_c.count = accum_q[CNT_W-1:0];
					end
				end
			end
			PH_BULK: begin
				r_valid = 1'b1;
				r_kind  = K_BULK;
				r_has   = 1'b1;
				r_byte  = byte_s1;
				left_d  = left_q - CNT_W'(1);
			end
			PH_TAIL: begin
				if (is_lf) begin
					r_valid   = 1'b1;
					r_kind    = K_BULK;
					r_number  = accum_q;
					r_ovf     = ovf_q;
					r_end     = 1'b1;
					r_rend    = stk_stat.last;
					cmd_c.pop = 1'b1;
				end
			end
			PH_SKIP: begin
				r_valid = 1'b0;
			end
			default: begin
				r_valid = 1'b0;
			end
		endcase
	end

	assign stk_cmd.push  = cmd_c.push && step;
	assign stk_cmd.pop   = cmd_c.pop && step;
	assign stk_cmd.clear = cmd_c.clear && step;
	assign stk_cmd.count = cmd_c.count;

	resp_stack #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (stk_cmd),
		.stat   (stk_stat),
		.depth  (depth)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			etype_q <= K_SIMPLE;
			accum_q <= 32'd0;
			neg_q   <= 1'b0;
			ovf_q   <= 1'b0;
			left_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			etype_q <= etype_d;
			accum_q <= accum_d;
			neg_q   <= neg_d;
			ovf_q   <= ovf_d;
			left_q  <= left_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= r_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && r_valid) begin
			kind_q    <= r_kind;
			has_q     <= r_has;
			byte_q    <= r_byte;
			number_q  <= r_number;
			ovf_out_q <= r_ovf;
			end_q     <= r_end;
			nest_q    <= 3'(depth);
			rend_q    <= r_rend;
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = kind_q;
	assign has_byte        = has_q;
	assign payload_byte    = byte_q;
	assign number          = $signed(number_q);
	assign number_overflow = ovf_out_q;
	assign element_end     = end_q;
	assign nest_level      = nest_q;
	assign reply_end       = rend_q;

endmodule

### hw/rtl/resp_chk.sv
`include "resp_reply_parser_assert.svh"

module resp_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [2:0]         kind,
	input logic               has_byte,
	input logic [7:0]         payload_byte,
	input logic signed [31:0] number,
	input logic               element_end,
	input logic               reply_end
);
	import resp_pkg::*;

	`RESP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(payload_byte) && $stable(number), "result item changed while stalled")
	`RESP_ASSERT_NOW(a_rend_closes, out_valid && reply_end, element_end, "reply end without element end")
	`RESP_ASSERT_NOW(a_byte_open, out_valid && has_byte && kind != K_BAD, !element_end && number == 32'sd0, "byte item closes an element")
	`RESP_ASSERT_NOW(a_no_byte_zero, out_valid && !has_byte, payload_byte == 8'd0, "payload byte set without a byte")

endmodule

bind resp_reply_parser resp_chk u_resp_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.kind         (kind),
	.has_byte     (has_byte),
	.payload_byte (payload_byte),
	.number       (number),
	.element_end  (element_end),
	.reply_end    (reply_end)
);

### sim/resp_reply_parser_tb.sv
module resp_reply_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import resp_pkg::*;

	localparam int NEST_MAX    = 4;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;

	typedef struct packed {
		kind_t       kind;
		logic        has;
		logic [7:0]  pbyte;
		logic [31:0] num;
		logic        ovf;
		logic        eend;
		logic [2:0]  nest;
		logic        rend;
	} token_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         rx_byte;
	logic               out_valid;
	logic               out_ready;
	logic [2:0]         kind;
	logic               has_byte;
	logic [7:0]         payload_byte;
	logic signed [31:0] number;
	logic               number_overflow;
	logic               element_end;
	logic [2:0]         nest_level;
	logic               reply_end;

	resp_reply_parser #(.MAX_DEPTH(NEST_MAX)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.has_byte(has_byte),
		.payload_byte(payload_byte),
		.number(number),
		.number_overflow(number_overflow),
		.element_end(element_end),
		.nest_level(nest_level),
		.reply_end(reply_end)
	);

	logic [7:0] reply_bytes [$];
	token_t     predicted_tokens [$];

	ph_t         st_phase = PH_TYPE;
	kind_t       st_type  = K_SIMPLE;
	logic [31:0] st_mag   = '0;
	logic        st_neg   = 1'b0;
	logic        st_ovf   = 1'b0;
	logic [31:0] st_left  = '0;
	logic [31:0] st_counts [NEST_MAX];
	int          st_depth = 0;

	bit in_took, out_took, calm, holding;
	int in_gap, out_gap, hold_left;
	int bytes_accepted, results_seen, idle_cycles, errors;
	int n_replies, n_bad, n_ovf, n_null, max_nest;

	function automatic logic count_down_arrays();
		st_phase = PH_TYPE;
		while (st_depth != 0) begin
			st_counts[st_depth - 1] -= 1;
			if (st_counts[st_depth - 1] != 0)
				return 1'b0;
			st_depth--;
		end
		return 1'b1;
	endfunction

	function automatic bit parse_reply_byte(input logic [7:0] b, output token_t r);
		logic [63:0] acc;
		logic [31:0] lim;
		r = '0;
		r.nest = st_depth[2:0];
		case (st_phase)
			PH_TYPE: begin
				st_mag = '0;
				st_neg = 1'b0;
				st_ovf = 1'b0;
				st_left = '0;
				case (b)
					CH_PLUS: begin
						st_type = K_SIMPLE;
						st_phase = PH_LINE;
					end
					CH_MINUS: begin
						st_type = K_ERROR;
						st_phase = PH_LINE;
					end
					CH_COLON: begin
						st_type = K_INT;
						st_phase = PH_NUM;
					end
					CH_DOLLAR: begin
						st_type = K_BULK;
						st_phase = PH_NUM;
					end
					CH_STAR: begin
						st_type = K_ARRAY;
						st_phase = PH_NUM;
					end
					default: begin
						r.kind = K_BAD;
						r.has = 1'b1;
						r.pbyte = b;
						r.eend = 1'b1;
						r.rend = 1'b1;
						st_depth = 0;
						st_phase = (b == CH_LF) ? PH_TYPE : PH_SKIP;
						return 1'b1;
					end
				endcase
				return 1'b0;
			end
			PH_LINE: begin
				if (b == CH_CR)
					return 1'b0;
				r.kind = st_type;
				if (b == CH_LF) begin
					r.eend = 1'b1;
					r.rend = count_down_arrays();
				end else begin
					r.has = 1'b1;
					r.pbyte = b;
				end
				return 1'b1;
			end
			PH_NUM: begin
				if (b >= CH_ZERO && b <= CH_NINE) begin
					lim = st_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
					acc = 64'(st_mag) * 10 + 64'(b - CH_ZERO);
					if (acc > 64'(lim)) begin
						acc = 64'(lim);
						st_ovf = 1'b1;
					end
					st_mag = acc[31:0];
					return 1'b0;
				end
				if (b == CH_MINUS && st_mag == 0) begin
					st_neg = 1'b1;
					return 1'b0;
				end
				if (b != CH_LF)
					return 1'b0;
				r.num = st_neg ? 32'd0 - st_mag : st_mag;
				r.ovf = st_ovf;
				r.eend = 1'b1;
				if (st_type == K_INT) begin
					r.kind = K_INT;
					r.rend = count_down_arrays();
					return 1'b1;
				end
				if (st_neg && st_mag != 0) begin
					r.kind = K_NULL;
					r.rend = count_down_arrays();
					return 1'b1;
				end
				if (st_type == K_BULK) begin
					st_left = st_mag;
					st_phase = (st_mag == 0) ? PH_TAIL : PH_BULK;
					return 1'b0;
				end
				r.kind = K_ARRAY;
				if (st_mag == 0) begin
					r.num = '0;
					r.rend = count_down_arrays();
					return 1'b1;
				end
				st_phase = PH_TYPE;
				if (st_depth >= NEST_MAX) begin
					r.kind = K_BAD;
					r.rend = 1'b1;
					st_depth = 0;
					return 1'b1;
				end
				st_counts[st_depth] = st_mag;
				st_depth++;
				return 1'b1;
			end
			PH_BULK: begin
				r.kind = K_BULK;
				r.has = 1'b1;
				r.pbyte = b;
				st_left -= 1;
				if (st_left == 0)
					st_phase = PH_TAIL;
				return 1'b1;
			end
			PH_TAIL: begin
				if (b != CH_LF)
					return 1'b0;
				r.kind = K_BULK;
				r.num = st_mag;
				r.ovf = st_ovf;
				r.eend = 1'b1;
				r.rend = count_down_arrays();
				return 1'b1;
			end
			default: begin
				if (b == CH_LF)
					st_phase = PH_TYPE;
				return 1'b0;
			end
		endcase
	endfunction

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 11);
	endfunction

	function automatic logic [7:0] noise_byte();
		logic [7:0] c;
		c = 8'($urandom);
		if (c == CH_LF)
			c = CH_CR;
		return c;
	endfunction

	function automatic longint pick_int();
		case ($urandom_range(0, 8))
			0: return $urandom_range(0, 99);
			1: return -longint'($urandom_range(0, 99));
			2: return longint'($urandom);
			3: return -longint'($urandom);
			4: return longint'({$urandom, $urandom});
			5: return 64'sd2147483647 + $urandom_range(0, 1);
			6: return -64'sd2147483648 - $urandom_range(0, 1);
			7: return 0;
			default: return longint'(int'($urandom));
		endcase
	endfunction

	task automatic add_byte(input logic [7:0] b);
		reply_bytes.insert(reply_bytes.size(), b);
	endtask

	task automatic push_str(input string s);
		foreach (s[i])
			add_byte(s[i]);
	endtask

	task automatic push_eol();
		if ($urandom_range(0, 7) == 0)
			add_byte(CH_LF);
		else
			push_str("\r\n");
	endtask

	task automatic push_text();
		logic [7:0] c;
		repeat ($urandom_range(0, 6)) begin
			c = ($urandom_range(0, 3) == 0) ? noise_byte() : 8'($urandom_range(32, 126));
			add_byte(c);
		end
		push_eol();
	endtask

	task automatic push_number(input longint v, input bit messy);
		string s;
		int at;
		s = $sformatf("%0d", v);
		at = (messy && $urandom_range(0, 7) == 0) ? $urandom_range(0, s.len()) : -1;
		for (int i = 0; i <= s.len(); i++) begin
			if (i == at)
				add_byte(noise_byte());
			if (i < s.len())
				add_byte(s[i]);
		end
		push_eol();
	endtask

	task automatic add_element(input int lvl);
		int sel, n;
		sel = $urandom_range(0, 9);
		if (lvl > NEST_MAX && sel >= 6)
			sel = $urandom_range(0, 5);
		case (sel)
			0: begin
				add_byte(CH_PLUS);
				push_text();
			end
			1: begin
				add_byte(CH_MINUS);
				push_text();
			end
			2: begin
				add_byte(CH_COLON);
				push_number(pick_int(), 1'b1);
			end
			3, 4, 5: begin
				add_byte(CH_DOLLAR);
				if ($urandom_range(0, 5) == 0) begin
					push_number(($urandom_range(0, 3) == 0) ? -longint'($urandom) - 1 : -1, 1'b0);
				end else begin
					n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
					push_number(n, 1'b0);
					repeat (n)
						add_byte(8'($urandom));
					if ($urandom_range(0, 4) == 0)
						repeat ($urandom_range(1, 3))
							add_byte(noise_byte());
					push_eol();
				end
			end
			default: begin
				add_byte(CH_STAR);
				if ($urandom_range(0, 7) == 0) begin
					push_number(-1, 1'b0);
				end else begin
					n = $urandom_range(0, 3);
					push_number(n, 1'b0);
					repeat (n)
						add_element(lvl + 1);
				end
			end
		endcase
	endtask

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= 60)
			$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
				results_seen, name, got, want));
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin : monitor
		token_t t;
		in_took = arst_n && in_valid && in_ready;
		out_took = arst_n && out_valid && out_ready;
		holding = (hold_left > 0);
		if (in_took) begin
			bytes_accepted++;
			if (bytes_accepted % 128 == 0)
				calm = ($urandom_range(0, 2) == 0);
			if (parse_reply_byte(rx_byte, t))
				predicted_tokens.insert(predicted_tokens.size(), t);
		end
		if (out_took) begin
			results_seen++;
			if (predicted_tokens.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with none predicted", results_seen));
			end else begin
				t = predicted_tokens[0];
				predicted_tokens.delete(0);
				check_field("kind", 32'(kind), 32'(t.kind));
				check_field("has_byte", 32'(has_byte), 32'(t.has));
				check_field("payload_byte", 32'(payload_byte), 32'(t.pbyte));
				check_field("number", number, t.num);
				check_field("number_overflow", 32'(number_overflow), 32'(t.ovf));
				check_field("element_end", 32'(element_end), 32'(t.eend));
				check_field("nest_level", 32'(nest_level), 32'(t.nest));
				check_field("reply_end", 32'(reply_end), 32'(t.rend));
				n_replies += t.rend;
				n_bad += (t.kind == K_BAD);
				n_null += (t.kind == K_NULL);
				n_ovf += t.ovf;
				if (int'(t.nest) > max_nest)
					max_nest = t.nest;
			end
		end
		if (in_took || out_took)
			idle_cycles = 0;
		else
			idle_cycles++;
	end

	always @(negedge clk) begin : driver
		bit nv;
		if (arst_n) begin
			nv = in_valid;
			if (in_valid && in_took) begin
				nv = 1'b0;
				in_gap = holding ? 0 : draw_gap();
			end
			if (!nv) begin
				if (in_gap > 0 && !holding) begin
					in_gap--;
				end else if (reply_bytes.size() > 0) begin
					rx_byte <= reply_bytes[0];
					reply_bytes.delete(0);
					nv = 1'b1;
				end
			end
			in_valid <= nv;
		end
	end

	always @(negedge clk) begin : receiver
		if (arst_n) begin
			if (out_took) begin
				out_gap = draw_gap();
				if (results_seen == 200 || results_seen == 600)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		do
			@(negedge clk);
		while (idle_cycles < STALL_LIMIT);
		$display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		int total, target, start, keep, n;
		logic [7:0] c;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		out_ready = 1'b0;

		add_byte(8'h00);
		push_str("\n\n*2\r\n+");
		add_byte(8'hFF);
		push_str("\r\n$0\r\n\r\n-E\n$-1\n*0\n");

		target = reply_bytes.size() + 1400;
		while (reply_bytes.size() < target) begin
			case ($urandom_range(0, 19))
				0, 1: begin
					c = 8'($urandom);
					if (c inside {CH_PLUS, CH_MINUS, CH_COLON, CH_DOLLAR, CH_STAR})
						c = 8'h00;
					add_byte(c);
					if (c != CH_LF) begin
						repeat ($urandom_range(0, 5))
							add_byte(noise_byte());
						add_byte(CH_LF);
					end
				end
				2: begin
					start = reply_bytes.size();
					add_element(0);
					keep = $urandom_range(start + 1, reply_bytes.size() - 1);
					while (reply_bytes.size() > keep)
						reply_bytes.delete(reply_bytes.size() - 1);
					push_str("\r\n");
				end
				3, 4: begin
					n = $urandom_range(3, NEST_MAX + 2);
					repeat (n)
						push_str("*1\r\n");
					add_element(NEST_MAX + 1);
				end
				default: add_element(0);
			endcase
		end
		push_str("$99999999999\r\n");
		repeat (30)
			add_byte(8'($urandom));
		total = reply_bytes.size();

		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (bytes_accepted < total || predicted_tokens.size() != 0)
			@(negedge clk);
		repeat (8)
			@(negedge clk);

		$display("Fed %0d reply bytes and checked %0d results, closing %0d replies.",
			bytes_accepted, results_seen, n_replies);
		$display("Seen: %0d bad or too-deep, %0d null, %0d saturated, nesting up to %0d.",
			n_bad, n_null, n_ovf, max_nest);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/resp_pkg.sv
hw/rtl/resp_num.sv
hw/rtl/resp_stack.sv
hw/rtl/resp_reply_parser.sv
hw/rtl/resp_chk.sv
sim/resp_reply_parser_tb.sv
